// File: hdl/eatrm_pkg.sv
// ----------------------------------------------------------------------------
// eatrm_pkg: shared types and constants
// Payload structs, CORDIC constants and the arctangent table for the
// Euler angle to direction cosine matrix block.
// ----------------------------------------------------------------------------
package eatrm_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned TableLen = 24;

  // Q30 start value of x (CORDIC gain folded in).
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam logic signed [24:0] HalfPiQ20 = 25'sd1647099;
  localparam logic signed [24:0] PiQ20 = 25'sd3294199;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_beat_t;

  // Sine and cosine of one angle, signed Q15.
  typedef struct packed {
    logic signed [16:0] c;
    logic signed [16:0] s;
  } sc_t;

  function automatic logic signed [24:0] atan_q20(input int unsigned k);
    logic signed [24:0] r;
    r = '0;
    case (k)
      0: r = 25'sd823550;
      1: r = 25'sd486170;
      2: r = 25'sd256879;
      3: r = 25'sd130396;
      4: r = 25'sd65451;
      5: r = 25'sd32757;
      6: r = 25'sd16383;
      7: r = 25'sd8192;
      8: r = 25'sd4096;
      9: r = 25'sd2048;
      10: r = 25'sd1024;
      11: r = 25'sd512;
      12: r = 25'sd256;
      13: r = 25'sd128;
      14: r = 25'sd64;
      15: r = 25'sd32;
      16: r = 25'sd16;
      17: r = 25'sd8;
      18: r = 25'sd4;
      19: r = 25'sd2;
      20: r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round to Q14 (halves up) by an arithmetic shift, then clamp to +-1.0.
  function automatic logic signed [15:0] round_clamp(input logic signed [63:0] v,
                                                     input int unsigned sh);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r[15:0];
  endfunction

endpackage

// File: hdl/euler_angles_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix: ZYX Euler angles to rotation matrix
// Three pipelined CORDICs give sine and cosine of each angle; a product
// pipeline forms the nine Q1.14 matrix entries, clamped to +-1.0.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in      | input     | in_valid_i/stall_o  | in_beat_t (three Q3.13 angles)
//   out     | output    | out_valid_o/stall_i | out_beat_t (nine Q1.14 entries)
//
// A beat is taken every cycle while the output beat is not stalled.
// The CORDIC stage count sets the depth; each CORDIC stage is one add/sub.
// Reset clears only the valid bits. When the output beat is stalled, the
// whole pipe holds, unless the output slot is empty, so no beat is lost.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix
  import eatrm_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  logic      en;
  logic      cv;
  sc_t [2:0] sc;

  // The pipe advances whenever the final slot is empty or is being taken.
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  eatrm_cordic #(.CordicStages(CORDIC_STAGES)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .beat_i(in_beat_i),
    .valid_o(cv), .sc_o(sc)
  );

  eatrm_matrix u_matrix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cv), .sc_i(sc),
    .valid_o(out_valid_o), .beat_o(out_beat_o)
  );

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");
  a_m22_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.m22 <= OneQ14 && out_beat_o.m22 >= -OneQ14)
    else $error("entry out of range");
`endif

endmodule

// File: hdl/eatrm_cordic.sv
// ----------------------------------------------------------------------------
// eatrm_cordic: pipelined rotation-mode CORDIC
// One stage per register; takes three angles per beat and gives the
// sine and cosine of each in Q15. Stalls freeze the whole pipe.
// ----------------------------------------------------------------------------
module eatrm_cordic
  import eatrm_pkg::*;
#(
  parameter int unsigned CordicStages = CordicStagesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  in_beat_t       beat_i,
  output logic           valid_o,
  output sc_t [2:0]      sc_o
);

  localparam int unsigned NStg = (CordicStages < TableLen) ? CordicStages : TableLen;

  logic signed [33:0] x_q [NStg+1][3];
  logic signed [33:0] y_q [NStg+1][3];
  logic signed [24:0] z_q [NStg+1][3];
  logic               f_q [NStg+1][3];
  logic [NStg:0]      v_q;

  logic signed [24:0] z0 [3];
  logic               f0 [3];
  logic signed [15:0] ang [3];

  assign ang[0] = beat_i.angle_x;
  assign ang[1] = beat_i.angle_y;
  assign ang[2] = beat_i.angle_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      z0[a] = {{2{ang[a][15]}}, ang[a], 7'd0};
      f0[a] = 1'b0;
      if (z0[a] > HalfPiQ20) begin
        z0[a] = z0[a] - PiQ20;
        f0[a] = 1'b1;
      end else if (z0[a] < -HalfPiQ20) begin
        z0[a] = z0[a] + PiQ20;
        f0[a] = 1'b1;
      end
    end
  end

  // Stage 0 register holds the folded angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        x_q[0][a] <= CordicGainQ30;
        y_q[0][a] <= '0;
        z_q[0][a] <= z0[a];
        f_q[0][a] <= f0[a];
      end
    end
  end

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int a = 0; a < 3; a++) begin
          f_q[k+1][a] <= f_q[k][a];
          if (!z_q[k][a][24]) begin
            x_q[k+1][a] <= x_q[k][a] - (y_q[k][a] >>> k);
            y_q[k+1][a] <= y_q[k][a] + (x_q[k][a] >>> k);
            z_q[k+1][a] <= z_q[k][a] - atan_q20(k);
          end else begin
            x_q[k+1][a] <= x_q[k][a] + (y_q[k][a] >>> k);
            y_q[k+1][a] <= y_q[k][a] - (x_q[k][a] >>> k);
            z_q[k+1][a] <= z_q[k][a] + atan_q20(k);
          end
        end
      end
    end
  end

  logic signed [33:0] xr [3];
  logic signed [33:0] yr [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      xr[a] = (x_q[NStg][a] + 34'sd16384) >>> 15;
      yr[a] = (y_q[NStg][a] + 34'sd16384) >>> 15;
      sc_o[a].c = f_q[NStg][a] ? -xr[a][16:0] : xr[a][16:0];
      sc_o[a].s = f_q[NStg][a] ? -yr[a][16:0] : yr[a][16:0];
    end
  end

  assign valid_o = v_q[NStg];

endmodule

// File: hdl/eatrm_matrix.sv
// ----------------------------------------------------------------------------
// eatrm_matrix: direction cosine matrix from sines and cosines
// Two multiply stages (pair products, then triple products) and a
// rounding and clamping stage.
// ----------------------------------------------------------------------------
module eatrm_matrix
  import eatrm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  sc_t [2:0]  sc_i,
  output logic       valid_o,
  output out_beat_t  beat_o
);

  // Stage A: two-factor products, Q30.
  logic signed [33:0] sysx_q, sycx_q, szcx_q, szsx_q, czcx_q, czsx_q;
  logic signed [33:0] cycz_q, cysz_q, cysx_q, cycx_q;
  logic signed [16:0] sy_q, cz_q, sz_q;
  logic signed [16:0] cx, sx, cy, sy, cz, sz;
  logic [2:0] v_q;

  assign cx = sc_i[0].c; assign sx = sc_i[0].s;
  assign cy = sc_i[1].c; assign sy = sc_i[1].s;
  assign cz = sc_i[2].c; assign sz = sc_i[2].s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sysx_q <= sy * sx; sycx_q <= sy * cx;
      szcx_q <= sz * cx; szsx_q <= sz * sx;
      czcx_q <= cz * cx; czsx_q <= cz * sx;
      cycz_q <= cy * cz; cysz_q <= cy * sz;
      cysx_q <= cy * sx; cycx_q <= cy * cx;
      sy_q <= sy; cz_q <= cz; sz_q <= sz;
    end
  end

  // Stage B: triple products combined in Q45; pair products and -sy pass on.
  logic signed [51:0] e01_q, e02_q, e11_q, e12_q;
  logic signed [33:0] e00_q, e10_q, e21_q, e22_q;
  logic signed [16:0] e20_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e01_q <= 52'(sysx_q * cz_q) - (52'(szcx_q) <<< 15);
      e02_q <= 52'(sycx_q * cz_q) + (52'(szsx_q) <<< 15);
      e11_q <= 52'(sysx_q * sz_q) + (52'(czcx_q) <<< 15);
      e12_q <= 52'(sycx_q * sz_q) - (52'(czsx_q) <<< 15);
      e00_q <= cycz_q; e10_q <= cysz_q; e21_q <= cysx_q; e22_q <= cycx_q;
      e20_q <= -sy_q;
    end
  end

  // Stage C: round and clamp.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_o.m00 <= round_clamp(64'(e00_q), 16);
      beat_o.m01 <= round_clamp(64'(e01_q), 31);
      beat_o.m02 <= round_clamp(64'(e02_q), 31);
      beat_o.m10 <= round_clamp(64'(e10_q), 16);
      beat_o.m11 <= round_clamp(64'(e11_q), 31);
      beat_o.m12 <= round_clamp(64'(e12_q), 31);
      beat_o.m20 <= round_clamp(64'(e20_q), 1);
      beat_o.m21 <= round_clamp(64'(e21_q), 16);
      beat_o.m22 <= round_clamp(64'(e22_q), 16);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  assign valid_o = v_q[2];

endmodule

// File: test/tb_euler_angles_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_matrix: self-checking bench for the DCM block
// Drives angle triples with random bursts and gaps while the output side
// stalls on its own pattern. A local fixed-point CORDIC predicts each beat of
// nine matrix entries; results are checked in order, the whole beat at once.
// ----------------------------------------------------------------------------
module tb_euler_angles_to_rotation_matrix;
  import eatrm_pkg::*;

  localparam int unsigned Stages = CordicStagesDef;
  localparam int unsigned Latency = Stages + 5;
  localparam int unsigned NumRandom = 1650;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  // Angle triples waiting to be driven, and matrices waiting to come back.
  in_beat_t angle_queue[$];
  out_beat_t matrix_queue[$];
  int unsigned mismatches = 0;
  longint cycles = 0;
  // Set by the stimulus to hold the sender while the first random triples queue.
  bit hold_sender = 1'b0;
  // High when the input beat was accepted at the last rising edge.
  bit in_taken = 1'b0;

  euler_angles_to_rotation_matrix dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always #6 clk_i = ~clk_i;

  // Adds half an LSB before the arithmetic right shift, which alone rounds toward
  // minus infinity, so the result rounds half up, as the CORDIC output does.
  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v, input int sh);
    longint r;
    r = round_half_up(v, sh);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Rotation-mode CORDIC on one Q3.13 angle; gives cosine and sine in Q15.
  // Angles beyond +-pi/2 are folded by pi, which negates both outputs.
  task automatic cordic_sin_cos(input logic signed [15:0] angle,
                                output longint cos_q15, output longint sin_q15);
    longint z, x, y, dx, dy;
    longint atan_tab[24];
    bit flip;
    atan_tab = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                 4096, 2048, 1024, 512, 256, 128, 64, 32,
                 16, 8, 4, 2, 1, 0, 0, 0};
    z = longint'(angle) * 128;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 1647099) begin
      z -= 3294199;
      flip = 1'b1;
    end else if (z < -1647099) begin
      z += 3294199;
      flip = 1'b1;
    end
    for (int k = 0; k < Stages && k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[k];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[k];
      end
    end
    x = round_half_up(x, 15);
    y = round_half_up(y, 15);
    cos_q15 = flip ? -x : x;
    sin_q15 = flip ? -y : y;
  endtask

  // Direction cosine matrix (ZYX order) expected for one angle triple.
  task automatic predict_matrix(input in_beat_t a);
    longint cx, sx, cy, sy, cz, sz;
    out_beat_t m;
    cordic_sin_cos(a.angle_x, cx, sx);
    cordic_sin_cos(a.angle_y, cy, sy);
    cordic_sin_cos(a.angle_z, cz, sz);
    m.m00 = to_q14(cy * cz, 16);
    m.m01 = to_q14(sy * sx * cz - sz * cx * 32768, 31);
    m.m02 = to_q14(sy * cx * cz + sz * sx * 32768, 31);
    m.m10 = to_q14(cy * sz, 16);
    m.m11 = to_q14(sy * sx * sz + cz * cx * 32768, 31);
    m.m12 = to_q14(sy * cx * sz - cz * sx * 32768, 31);
    m.m20 = to_q14(-sy, 1);
    m.m21 = to_q14(cy * sx, 16);
    m.m22 = to_q14(cy * cx, 16);
    matrix_queue.push_back(m);
  endtask

  function automatic in_beat_t rand_triple();
    in_beat_t a;
    a.angle_x = 16'($urandom);
    a.angle_y = 16'($urandom);
    a.angle_z = 16'($urandom);
    return a;
  endfunction

  // Acceptance is sampled at the rising edge, where the handshake happens.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  // Driver: bursts of beats separated by random gaps, at the falling edge.
  // Valid only drops between beats and a stalled beat is held as it is.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_valid_i) begin
        // The previous beat was taken at the last rising edge.
        predict_matrix(in_beat_i);
        void'(angle_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (angle_queue.size() == 0 || hold_sender) begin
        in_valid_i <= 1'b0;
      end else begin
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 12);
        in_beat_i <= angle_queue[0];
        in_valid_i <= 1'b1;
      end
    end
  end

  // The receiver stalls on its own pattern: quiet stretches, then phases
  // of random stall with a density that changes from phase to phase.
  int stall_phase = 0;
  int stall_pct = 0;
  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(20, 120);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
    end
    stall_phase--;
    out_stall_i <= ($urandom_range(1, 100) <= stall_pct);
  end

  // Monitor: compare each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (matrix_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %h", out_beat_o);
        end else if (out_beat_o !== matrix_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("matrix mismatch: expected %h actual %h",
                     matrix_queue[0], out_beat_o);
          void'(matrix_queue.pop_front());
        end else begin
          void'(matrix_queue.pop_front());
        end
      end
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (angle_queue.size() != 0 || in_valid_i || matrix_queue.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic signed [15:0] corners[8];
    in_beat_t a;
    corners = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
                16'sd12868, -16'sd12868, 16'sd25736};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes, zero, about +-pi/2 and pi, where the fold
    // kicks in, and the sign boundaries of every angle.
    for (int i = 0; i < 8; i++) begin
      a.angle_x = corners[i];
      a.angle_y = corners[(i + 3) % 8];
      a.angle_z = corners[(i + 5) % 8];
      angle_queue.push_back(a);
    end
    for (int i = 0; i < 8; i++) begin
      a.angle_x = corners[i];
      a.angle_y = corners[i];
      a.angle_z = corners[i];
      angle_queue.push_back(a);
    end
    angle_queue.push_back('{16'sd12867, 16'sd12868, 16'sd12869});
    angle_queue.push_back('{-16'sd12867, -16'sd12868, -16'sd12869});
    angle_queue.push_back('{16'sd25735, 16'sd6434, -16'sd6434});

    // Once the pipe is empty, pause the sender while triples queue, then go random.
    wait_drained();
    hold_sender = 1'b1;
    for (int i = 0; i < NumRandom / 2; i++) angle_queue.push_back(rand_triple());
    repeat (Latency) @(posedge clk_i);
    hold_sender = 1'b0;
    wait_drained();
    for (int i = 0; i < NumRandom / 2; i++) angle_queue.push_back(rand_triple());
    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && matrix_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/eatrm_pkg.sv
hdl/eatrm_cordic.sv
hdl/eatrm_matrix.sv
hdl/euler_angles_to_rotation_matrix.sv
test/tb_euler_angles_to_rotation_matrix.sv
